### rtl/esc_pkg.sv
// Shared constants, types and helpers for the environmental sensor compensation block.
package esc_pkg;

   localparam int DW = 64;

   localparam logic [23:0] TEMP_OFF   = 24'h800000;
   localparam logic [23:0] PRESS_OFF  = 24'h800000;
   localparam logic [15:0] HUM_OFF    = 16'h8000;
   localparam logic [32:0] P_FINE_OFF = 33'd128000;
   localparam logic [20:0] P_BASE     = 21'd1048576;
   localparam logic [11:0] P_SCALE    = 12'd3125;
   localparam logic [31:0] H_FINE_OFF = 32'd76800;
   localparam logic [31:0] H_ROUND_A  = 32'd16384;
   localparam logic [31:0] H_BIAS     = 32'd2097152;
   localparam logic [31:0] H_ROUND_B  = 32'd8192;
   localparam logic [31:0] H_MAX      = 32'd419430400;
   localparam logic [31:0] H_HALF     = 32'd32768;
   localparam logic [63:0] P_BIAS47   = 64'h0000_8000_0000_0000;
   localparam logic [16:0] HUM_LIMIT  = 17'd102400;

   // pipeline depths
   localparam int TEMP_LAT   = 3;
   localparam int CENTI_LAT  = 4;
   localparam int HUM_LAT    = 12;
   localparam int DIV_LAT    = DW + 2;
   localparam int PF_LAT     = 5;
   localparam int PB_LAT     = 7;
   localparam int PRESS_LAT  = PF_LAT + DIV_LAT + PB_LAT;
   localparam int TOTAL_LAT  = TEMP_LAT + PRESS_LAT;

   typedef enum logic [2:0] {
      CSR_TEMP    = 3'd0,
      CSR_PRESS_A = 3'd1,
      CSR_PRESS_B = 3'd2,
      CSR_MIXED   = 3'd3,
      CSR_HUM     = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [47:0] temp;
      logic [63:0] press_a;
      logic [63:0] press_b;
      logic [47:0] mixed;
      logic [31:0] hum;
   } cal_type;

   function automatic logic [63:0] sx64(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx32_12(input logic [11:0] v);
      return {{20{v[11]}}, v};
   endfunction

endpackage

### rtl/env_sensor_compensation.sv
// Top level of the environmental sensor compensation block: registers, alignment, result port.
//
//  channel   direction  handshake                      payload
//  request   in         start & !busy                  req_raw_temp_reg, req_raw_press_reg,
//                                                      req_raw_hum_reg
//  result    out        rsp_strobe (one cycle)         rsp_fine_temp .. rsp_hum_valid
//  csr       in         csr_valid & csr_ready          csr_index, csr_wdata
//
//  Fully pipelined: one request per cycle.
//  Latency is set by the 64-stage pressure divider plus the terms around it.
//  busy is never raised; csr_ready is always high.
//  Reset clears the calibration registers and the valid line; no stalls exist.
module env_sensor_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [23:0]        req_raw_temp_reg,
   input  logic [23:0]        req_raw_press_reg,
   input  logic [15:0]        req_raw_hum_reg,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_fine_temp,
   output logic signed [23:0] rsp_temp_centideg,
   output logic [31:0]        rsp_press_q24_8,
   output logic               rsp_press_valid,
   output logic [16:0]        rsp_hum_q22_10,
   output logic               rsp_hum_valid,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);
   import esc_pkg::*;

   localparam int FINE_DLY  = TOTAL_LAT - TEMP_LAT;
   localparam int CENTI_DLY = TOTAL_LAT - CENTI_LAT;
   localparam int HUM_DLY   = TOTAL_LAT - TEMP_LAT - HUM_LAT;

   cal_type cal_ff;
   logic    vld_ff [0:TOTAL_LAT-1];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TEMP:    cal_ff.temp    <= csr_wdata[47:0];
            CSR_PRESS_A: cal_ff.press_a <= csr_wdata;
            CSR_PRESS_B: cal_ff.press_b <= csr_wdata;
            CSR_MIXED:   cal_ff.mixed   <= csr_wdata[47:0];
            CSR_HUM:     cal_ff.hum     <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= start && !busy;
         for (int i = 1; i < TOTAL_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // raw pressure and humidity wait for the fine value
   logic [23:0] rawp_dly_ff [0:TEMP_LAT-1];
   logic [15:0] rawh_dly_ff [0:TEMP_LAT-1];

   always_ff @(posedge clock) begin
      rawp_dly_ff[0] <= req_raw_press_reg;
      rawh_dly_ff[0] <= req_raw_hum_reg;
      for (int i = 1; i < TEMP_LAT; i++) begin
         rawp_dly_ff[i] <= rawp_dly_ff[i-1];
         rawh_dly_ff[i] <= rawh_dly_ff[i-1];
      end
   end

   logic [31:0] fine;
   logic [23:0] centi;
   logic [31:0] press;
   logic        press_ok;
   logic [16:0] hum;
   logic        hum_ok;

   esc_temp u_temp (
      .clock    (clock),
      .raw_temp (req_raw_temp_reg),
      .cal      (cal_ff),
      .fine     (fine),
      .centi    (centi)
   );

   esc_press u_press (
      .clock     (clock),
      .fine      (fine),
      .raw_press (rawp_dly_ff[TEMP_LAT-1]),
      .cal       (cal_ff),
      .press     (press),
      .press_ok  (press_ok)
   );

   esc_hum u_hum (
      .clock   (clock),
      .fine    (fine),
      .raw_hum (rawh_dly_ff[TEMP_LAT-1]),
      .cal     (cal_ff),
      .hum     (hum),
      .hum_ok  (hum_ok)
   );

   logic [31:0] fine_dly_ff  [0:FINE_DLY-1];
   logic [23:0] centi_dly_ff [0:CENTI_DLY-1];
   logic [16:0] hum_dly_ff   [0:HUM_DLY-1];
   logic        hok_dly_ff   [0:HUM_DLY-1];

   always_ff @(posedge clock) begin
      fine_dly_ff[0]  <= fine;
      centi_dly_ff[0] <= centi;
      hum_dly_ff[0]   <= hum;
      hok_dly_ff[0]   <= hum_ok;
      for (int i = 1; i < FINE_DLY; i++) begin
         fine_dly_ff[i] <= fine_dly_ff[i-1];
      end
      for (int i = 1; i < CENTI_DLY; i++) begin
         centi_dly_ff[i] <= centi_dly_ff[i-1];
      end
      for (int i = 1; i < HUM_DLY; i++) begin
         hum_dly_ff[i] <= hum_dly_ff[i-1];
         hok_dly_ff[i] <= hok_dly_ff[i-1];
      end
   end

   assign rsp_strobe        = vld_ff[TOTAL_LAT-1];
   assign rsp_fine_temp     = $signed(fine_dly_ff[FINE_DLY-1]);
   assign rsp_temp_centideg = $signed(centi_dly_ff[CENTI_DLY-1]);
   assign rsp_press_q24_8   = press;
   assign rsp_press_valid   = press_ok;
   assign rsp_hum_q22_10    = hum_dly_ff[HUM_DLY-1];
   assign rsp_hum_valid     = hok_dly_ff[HUM_DLY-1];

   a_press_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_press_valid |-> rsp_press_q24_8 == '0)
      else $error("pressure not cleared when invalid");

   a_hum_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_hum_valid |-> rsp_hum_q22_10 == '0)
      else $error("humidity not cleared when invalid");

   a_hum_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_hum_q22_10 <= HUM_LIMIT)
      else $error("humidity above clamp");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##TOTAL_LAT rsp_strobe)
      else $error("request result missing");

endmodule

### rtl/esc_temp.sv
// Temperature compensation pipeline: fine value and hundredths of a degree.
module esc_temp (
   input  logic                clock,
   input  logic [23:0]         raw_temp,
   input  esc_pkg::cal_type    cal,
   output logic [31:0]         fine,
   output logic [23:0]         centi
);
   import esc_pkg::*;

   logic [19:0] adc;
   logic [15:0] t1;
   logic [31:0] t2;
   logic [31:0] t3;
   logic [31:0] a_in;
   logic [31:0] d_in;
   logic [31:0] pa_in;
   logic [31:0] dd_in;
   logic [31:0] pa_ff;
   logic [31:0] dd_ff;
   logic        off1_ff;
   logic [31:0] v1_ff;
   logic [31:0] m2_in;
   logic [31:0] m2_ff;
   logic        off2_ff;
   logic [31:0] fine_ff;
   logic [31:0] c_in;
   logic [23:0] centi_ff;

   assign adc   = raw_temp[23:4];
   assign t1    = cal.temp[15:0];
   assign t2    = {{16{cal.temp[31]}}, cal.temp[31:16]};
   assign t3    = {{16{cal.temp[47]}}, cal.temp[47:32]};
   assign a_in  = {15'b0, adc[19:3]} - {15'b0, t1, 1'b0};
   assign d_in  = {16'b0, adc[19:4]} - {16'b0, t1};
   assign pa_in = a_in * t2;
   assign dd_in = d_in * d_in;
   assign m2_in = 32'($signed(dd_ff) >>> 12) * t3;
   assign c_in  = fine_ff * 32'd5 + 32'd128;

   always_ff @(posedge clock) begin
      pa_ff    <= pa_in;
      dd_ff    <= dd_in;
      off1_ff  <= (raw_temp == TEMP_OFF);
      v1_ff    <= 32'($signed(pa_ff) >>> 11);
      m2_ff    <= m2_in;
      off2_ff  <= off1_ff;
      fine_ff  <= off2_ff ? 32'd0 : v1_ff + 32'($signed(m2_ff) >>> 14);
      centi_ff <= c_in[31:8];
   end

   assign fine  = fine_ff;
   assign centi = centi_ff;

endmodule

### rtl/esc_div.sv
// Pipelined signed 64-bit restoring divider, one quotient bit per stage.
module esc_div (
   input  logic                    clock,
   input  logic [esc_pkg::DW-1:0]  num,
   input  logic [esc_pkg::DW-1:0]  den,
   output logic [esc_pkg::DW-1:0]  quo
);
   import esc_pkg::*;

   logic [DW-1:0] rem_ff [0:DW];
   logic [DW-1:0] quo_ff [0:DW];
   logic [DW-1:0] den_ff [0:DW];
   logic          neg_ff [0:DW];
   logic [DW-1:0] out_ff;

   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      quo_ff[0] <= num[DW-1] ? (~num + 1'b1) : num;
      den_ff[0] <= den[DW-1] ? (~den + 1'b1) : den;
      neg_ff[0] <= num[DW-1] ^ den[DW-1];
   end

   for (genvar i = 0; i < DW; i++) begin : g_step
      logic [DW:0] trial;
      logic [DW:0] diff;
      assign trial = {rem_ff[i], quo_ff[i][DW-1]};
      assign diff  = trial - {1'b0, den_ff[i]};
      always_ff @(posedge clock) begin
         rem_ff[i+1] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
         quo_ff[i+1] <= {quo_ff[i][DW-2:0], ~diff[DW]};
         den_ff[i+1] <= den_ff[i];
         neg_ff[i+1] <= neg_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= neg_ff[DW] ? (~quo_ff[DW] + 1'b1) : quo_ff[DW];
   end

   assign quo = out_ff;

endmodule

### rtl/esc_press.sv
// Pressure compensation pipeline: coefficient terms, divider, correction and saturation.
module esc_press (
   input  logic                clock,
   input  logic [31:0]         fine,
   input  logic [23:0]         raw_press,
   input  esc_pkg::cal_type    cal,
   output logic [31:0]         press,
   output logic                press_ok
);
   import esc_pkg::*;

   localparam int OKL = DIV_LAT + PB_LAT + 1;

   logic        [15:0] p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

   assign p1 = cal.press_a[15:0];
   assign p2 = cal.press_a[31:16];
   assign p3 = cal.press_a[47:32];
   assign p4 = cal.press_a[63:48];
   assign p5 = cal.press_b[15:0];
   assign p6 = cal.press_b[31:16];
   assign p7 = cal.press_b[47:32];
   assign p8 = cal.press_b[63:48];
   assign p9 = cal.mixed[15:0];

   // front terms
   logic signed [32:0] f;
   logic signed [65:0] sq_full;
   logic signed [48:0] fp5_full, fp2_full;
   logic [63:0]        sq_ff;
   logic signed [48:0] fp5_ff, fp2_ff;
   logic               en1_ff, en2_ff, en3_ff, en4_ff;
   logic [19:0]        rp1_ff, rp2_ff, rp3_ff;
   logic signed [79:0] v2a_full, v1a_full;
   logic [63:0]        v2a_ff, v1a_ff, t5_ff, t2_ff;
   logic [63:0]        v2_ff, v1_ff;
   logic [79:0]        dm_full;
   logic [20:0]        pb;
   logic [63:0]        dm_ff, nn_ff;
   logic [75:0]        num_full;
   logic [63:0]        den_in;
   logic [63:0]        num_ff, den_ff;
   logic               ok_ff [0:OKL-1];

   assign f        = $signed({fine[31], fine}) - $signed(P_FINE_OFF);
   assign sq_full  = f * f;
   assign fp5_full = f * p5;
   assign fp2_full = f * p2;
   assign v2a_full = $signed(sq_ff) * p6;
   assign v1a_full = $signed(sq_ff) * p3;
   assign dm_full  = (P_BIAS47 + v1_ff) * p1;
   assign pb       = P_BASE - {1'b0, rp3_ff};
   assign num_full = nn_ff * P_SCALE;
   assign den_in   = 64'($signed(dm_ff) >>> 33);

   always_ff @(posedge clock) begin
      sq_ff  <= sq_full[63:0];
      fp5_ff <= fp5_full;
      fp2_ff <= fp2_full;
      en1_ff <= (raw_press != PRESS_OFF);
      rp1_ff <= raw_press[23:4];

      v2a_ff <= v2a_full[63:0];
      v1a_ff <= v1a_full[63:0];
      t5_ff  <= {{15{fp5_ff[48]}}, fp5_ff} << 17;
      t2_ff  <= {{15{fp2_ff[48]}}, fp2_ff} << 12;
      en2_ff <= en1_ff;
      rp2_ff <= rp1_ff;

      v2_ff  <= v2a_ff + t5_ff + (sx64(p4) << 35);
      v1_ff  <= 64'($signed(v1a_ff) >>> 8) + t2_ff;
      en3_ff <= en2_ff;
      rp3_ff <= rp2_ff;

      dm_ff  <= dm_full[63:0];
      nn_ff  <= {12'b0, pb, 31'b0} - v2_ff;
      en4_ff <= en3_ff;

      num_ff <= num_full[63:0];
      den_ff <= den_in;
   end

   always_ff @(posedge clock) begin
      ok_ff[0] <= en4_ff && (den_in != '0);
      for (int i = 1; i < OKL; i++) begin
         ok_ff[i] <= ok_ff[i-1];
      end
   end

   logic [63:0] quo;

   esc_div u_div (
      .clock (clock),
      .num   (num_ff),
      .den   (den_ff),
      .quo   (quo)
   );

   // back terms
   logic signed [79:0] pp8_full, m9_full;
   logic [63:0]        s1_ff, q1_ff, q2_ff, q3_ff, q4_ff;
   logic [63:0]        pp8_1_ff, pp8_2_ff, pp8_3_ff, pp8_4_ff;
   logic [63:0]        pa_in, pa_ff, ss_ff, m9_ff, sum_ff, pf_ff;
   logic [31:0]        pbx_in, pbx_ff;
   logic [31:0]        press_ff;

   assign pp8_full = $signed(quo) * p8;
   assign pa_in    = s1_ff[31:0] * s1_ff[31:0];
   assign pbx_in   = s1_ff[31:0] * s1_ff[63:32];
   assign m9_full  = $signed(ss_ff) * p9;

   always_ff @(posedge clock) begin
      s1_ff    <= 64'($signed(quo) >>> 13);
      pp8_1_ff <= pp8_full[63:0];
      q1_ff    <= quo;

      pa_ff    <= pa_in;
      pbx_ff   <= pbx_in;
      q2_ff    <= q1_ff;
      pp8_2_ff <= pp8_1_ff;

      ss_ff    <= pa_ff + {pbx_ff[30:0], 33'b0};
      q3_ff    <= q2_ff;
      pp8_3_ff <= pp8_2_ff;

      m9_ff    <= m9_full[63:0];
      q4_ff    <= q3_ff;
      pp8_4_ff <= pp8_3_ff;

      sum_ff   <= q4_ff + 64'($signed(m9_ff) >>> 25) + 64'($signed(pp8_4_ff) >>> 19);
      pf_ff    <= 64'($signed(sum_ff) >>> 8) + (sx64(p7) << 4);

      if (!ok_ff[OKL-2] || pf_ff[63]) begin
         press_ff <= '0;
      end else if (|pf_ff[62:32]) begin
         press_ff <= '1;
      end else begin
         press_ff <= pf_ff[31:0];
      end
   end

   assign press    = press_ff;
   assign press_ok = ok_ff[OKL-1];

endmodule

### rtl/esc_hum.sv
// Humidity compensation pipeline with clamp to 0..100 percent.
module esc_hum (
   input  logic                clock,
   input  logic [31:0]         fine,
   input  logic [15:0]         raw_hum,
   input  esc_pkg::cal_type    cal,
   output logic [16:0]         hum,
   output logic                hum_ok
);
   import esc_pkg::*;

   logic [31:0] h1, h2, h3, h4, h5, h6;
   logic [31:0] x, m5_in, xh6_in, xh3_in, base_in;
   logic [31:0] m5_ff, xh6_ff, xh3_ff, base_ff;
   logic [31:0] ta2_ff, ta3_ff, ta4_ff, ta5_ff, ta6_ff;
   logic [31:0] a6_ff, a3_ff, mi_ff, inner_ff, mb_ff, tb_ff;
   logic [31:0] x2_ff, x2b_ff, x2c_ff, x2d_ff, x2e_ff;
   logic [31:0] s_ff, ss_ff, t_ff, th_ff;
   logic [31:0] x3;
   logic [16:0] hum_ff;
   logic        en_ff [0:HUM_LAT-1];

   assign h1 = {24'b0, cal.mixed[23:16]};
   assign h2 = {{16{cal.mixed[39]}}, cal.mixed[39:24]};
   assign h3 = {24'b0, cal.mixed[47:40]};
   assign h4 = sx32_12(cal.hum[11:0]);
   assign h5 = sx32_12(cal.hum[23:12]);
   assign h6 = {{24{cal.hum[31]}}, cal.hum[31:24]};

   assign x       = fine - H_FINE_OFF;
   assign m5_in   = h5 * x;
   assign xh6_in  = x * h6;
   assign xh3_in  = x * h3;
   assign base_in = {2'b0, raw_hum, 14'b0} - {h4[11:0], 20'b0} + H_ROUND_A;
   assign x3      = x2e_ff - 32'($signed(th_ff) >>> 4);

   always_ff @(posedge clock) begin
      m5_ff    <= m5_in;
      xh6_ff   <= xh6_in;
      xh3_ff   <= xh3_in;
      base_ff  <= base_in;

      ta2_ff   <= 32'($signed(base_ff - m5_ff) >>> 15);
      a6_ff    <= 32'($signed(xh6_ff) >>> 10);
      a3_ff    <= 32'($signed(xh3_ff) >>> 11) + H_HALF;

      mi_ff    <= a6_ff * a3_ff;
      ta3_ff   <= ta2_ff;

      inner_ff <= 32'($signed(mi_ff) >>> 10) + H_BIAS;
      ta4_ff   <= ta3_ff;

      mb_ff    <= inner_ff * h2;
      ta5_ff   <= ta4_ff;

      tb_ff    <= 32'($signed(mb_ff + H_ROUND_B) >>> 14);
      ta6_ff   <= ta5_ff;

      x2_ff    <= ta6_ff * tb_ff;

      s_ff     <= 32'($signed(x2_ff) >>> 15);
      x2b_ff   <= x2_ff;

      ss_ff    <= s_ff * s_ff;
      x2c_ff   <= x2b_ff;

      t_ff     <= 32'($signed(ss_ff) >>> 7);
      x2d_ff   <= x2c_ff;

      th_ff    <= t_ff * h1;
      x2e_ff   <= x2d_ff;

      if (!en_ff[HUM_LAT-2] || x3[31]) begin
         hum_ff <= '0;
      end else if (x3 > H_MAX) begin
         hum_ff <= H_MAX[28:12];
      end else begin
         hum_ff <= x3[28:12];
      end
   end

   always_ff @(posedge clock) begin
      en_ff[0] <= (raw_hum != HUM_OFF);
      for (int i = 1; i < HUM_LAT; i++) begin
         en_ff[i] <= en_ff[i-1];
      end
   end

   assign hum    = hum_ff;
   assign hum_ok = en_ff[HUM_LAT-1];

endmodule

### verif/tb_env_sensor_compensation.sv
// Testbench for the environmental sensor compensation block: directed table, random sets, predictor.
module tb_env_sensor_compensation;
   import esc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [23:0] req_raw_temp_reg = '0;
   logic [23:0] req_raw_press_reg = '0;
   logic [15:0] req_raw_hum_reg = '0;
   logic        rsp_strobe;
   logic signed [31:0] rsp_fine_temp;
   logic signed [23:0] rsp_temp_centideg;
   logic [31:0] rsp_press_q24_8;
   logic        rsp_press_valid;
   logic [16:0] rsp_hum_q22_10;
   logic        rsp_hum_valid;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   typedef struct packed {
      logic [31:0] fine;
      logic [23:0] centi;
      logic [31:0] press;
      logic        pv;
      logic [16:0] hum;
      logic        hv;
   } comp_result_type;

   typedef struct {
      logic [23:0]     t;
      logic [23:0]     p;
      logic [15:0]     h;
      logic            known;
      comp_result_type res;
   } stim_row_type;

   env_sensor_compensation uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [47:0] cal_t;
   logic [63:0] cal_pa, cal_pb;
   logic [47:0] cal_m;
   logic [31:0] cal_h;
   comp_result_type expected_q[$];
   int errors = 0, results_seen = 0, sets_sent = 0;
   longint cycles = 0;
   bit idle_en = 1'b1;

   function automatic logic signed [63:0] s16(logic [63:0] w, int lo);
      logic [15:0] f;
      f = 16'(w >> lo);
      return {{48{f[15]}}, f};
   endfunction

   function automatic comp_result_type compensate(logic [23:0] rt, logic [23:0] rp,
                                                  logic [15:0] rh);
      comp_result_type r;
      logic signed [31:0] fine, adc, t1, t2, t3, a, d, v1, v2;
      logic signed [63:0] q1, q2, p, den;
      logic signed [31:0] h1, h2, h3, h4, h5, h6, x, ta, inner, tb, s;
      logic [11:0] h4f, h5f;
      logic [7:0] h6f;
      logic [63:0] mn, md, qq;
      fine = 0;
      r = '0;
      if (rt != TEMP_OFF) begin
         adc = $signed({12'd0, rt[23:4]});
         t1 = $signed({16'd0, cal_t[15:0]});
         t2 = 32'(s16({16'd0, cal_t}, 16));
         t3 = 32'(s16({16'd0, cal_t}, 32));
         a = (adc >>> 3) - (t1 <<< 1);
         v1 = (a * t2) >>> 11;
         d = (adc >>> 4) - t1;
         v2 = (((d * d) >>> 12) * t3) >>> 14;
         fine = v1 + v2;
      end
      if (rp != PRESS_OFF) begin
         q1 = 64'(fine) - 64'sd128000;
         q2 = q1 * q1 * s16(cal_pb, 16);
         q2 = q2 + ((q1 * s16(cal_pb, 0)) <<< 17);
         q2 = q2 + (s16(cal_pa, 48) <<< 35);
         q1 = ((q1 * q1 * s16(cal_pa, 32)) >>> 8) + ((q1 * s16(cal_pa, 16)) <<< 12);
         den = (((64'sd1 <<< 47) + q1) * $signed({48'd0, cal_pa[15:0]})) >>> 33;
         if (den != 0) begin
            p = 64'sd1048576 - $signed({44'd0, rp[23:4]});
            p = ((p <<< 31) - q2) * 64'sd3125;
            mn = p[63] ? -p : p;
            md = den[63] ? -den : den;
            qq = mn / md;
            p = (p[63] != den[63]) ? -qq : qq;
            q1 = (s16({16'd0, cal_m}, 0) * (p >>> 13) * (p >>> 13)) >>> 25;
            q2 = (s16(cal_pb, 48) * p) >>> 19;
            p = ((p + q1 + q2) >>> 8) + (s16(cal_pb, 32) <<< 4);
            if (p < 0) r.press = '0;
            else if (p > 64'sh0FFFFFFFF) r.press = '1;
            else r.press = p[31:0];
            r.pv = 1'b1;
         end
      end
      if (rh != HUM_OFF) begin
         h1 = $signed({24'd0, cal_m[23:16]});
         h2 = 32'(s16({16'd0, cal_m}, 24));
         h3 = $signed({24'd0, cal_m[47:40]});
         h4f = cal_h[11:0];
         h5f = cal_h[23:12];
         h6f = cal_h[31:24];
         h4 = {{20{h4f[11]}}, h4f};
         h5 = {{20{h5f[11]}}, h5f};
         h6 = {{24{h6f[7]}}, h6f};
         x = fine - 32'sd76800;
         ta = (($signed({16'd0, rh}) <<< 14) - (h4 <<< 20) - h5 * x + 32'sd16384) >>> 15;
         inner = ((((x * h6) >>> 10) * (((x * h3) >>> 11) + 32'sd32768)) >>> 10)
                 + 32'sd2097152;
         tb = (inner * h2 + 32'sd8192) >>> 14;
         x = ta * tb;
         s = x >>> 15;
         x = x - ((((s * s) >>> 7) * h1) >>> 4);
         if (x < 0) x = 0;
         else if (x > 32'sd419430400) x = 32'sd419430400;
         r.hum = x[28:12];
         r.hv = 1'b1;
      end
      r.fine = fine;
      r.centi = 24'((fine * 32'sd5 + 32'sd128) >>> 8);
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("** env_sensor_compensation: FAILED **");
         $finish;
      end
      if (!reset && rsp_strobe) begin
         results_seen <= results_seen + 1;
         if (expected_q.size() == 0) begin
            $error("result with no request pending");
            errors++;
         end else begin
            comp_result_type e;
            e = expected_q.pop_front();
            if (rsp_fine_temp !== e.fine) begin
               $error("fine_temp exp %0h got %0h", e.fine, rsp_fine_temp); errors++;
            end
            if (rsp_temp_centideg !== e.centi) begin
               $error("temp_centideg exp %0h got %0h", e.centi, rsp_temp_centideg);
               errors++;
            end
            if (rsp_press_q24_8 !== e.press) begin
               $error("press_q24_8 exp %0h got %0h", e.press, rsp_press_q24_8);
               errors++;
            end
            if (rsp_press_valid !== e.pv) begin
               $error("press_valid exp %0b got %0b", e.pv, rsp_press_valid); errors++;
            end
            if (rsp_hum_q22_10 !== e.hum) begin
               $error("hum_q22_10 exp %0h got %0h", e.hum, rsp_hum_q22_10); errors++;
            end
            if (rsp_hum_valid !== e.hv) begin
               $error("hum_valid exp %0b got %0b", e.hv, rsp_hum_valid); errors++;
            end
         end
      end
   end

   task automatic write_cal(csr_idx_type idx, logic [63:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TEMP:    cal_t = val[47:0];
         CSR_PRESS_A: cal_pa = val;
         CSR_PRESS_B: cal_pb = val;
         CSR_MIXED:   cal_m = val[47:0];
         CSR_HUM:     cal_h = val[31:0];
         default: ;
      endcase
   endtask

   task automatic send_set(logic [23:0] t, logic [23:0] p, logic [15:0] h, logic known,
                           comp_result_type res);
      comp_result_type e;
      while (idle_en && $urandom_range(99) < 25) begin
         start <= 1'b0;
         @(posedge clock);
      end
      e = compensate(t, p, h);
      if (known && e !== res) begin
         $error("table row disagrees with predictor");
         errors++;
      end
      start <= 1'b1;
      req_raw_temp_reg <= t;
      req_raw_press_reg <= p;
      req_raw_hum_reg <= h;
      do @(posedge clock); while (busy);
      expected_q.push_back(e);
      sets_sent++;
   endtask

   task automatic drain(int extra);
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic load_random_cal(int mode);
      logic [63:0] pa;
      if (mode == 0) begin
         write_cal(CSR_TEMP, 64'h0032_6768_6F7E);
         write_cal(CSR_PRESS_A, 64'h2336_0BD0_D66B_8F1A);
         write_cal(CSR_PRESS_B, 64'hE7DB_04B0_FFF9_0140);
         write_cal(CSR_MIXED, 64'h0000_1E01_664B_1770);
         write_cal(CSR_HUM, 64'h0000_0000_1E03_2150);
      end else begin
         write_cal(CSR_TEMP, {$urandom, $urandom});
         pa = {$urandom, $urandom};
         if (mode == 2) pa[15:0] = 16'hFFFF;
         write_cal(CSR_PRESS_A, pa);
         write_cal(CSR_PRESS_B, {$urandom, $urandom});
         write_cal(CSR_MIXED, {$urandom, $urandom});
         write_cal(CSR_HUM, {32'd0, $urandom});
      end
   endtask

   initial begin
      stim_row_type rows[$];
      comp_result_type z;
      logic [23:0] t, p;
      logic [15:0] h;
      int k;
      cal_t = '0; cal_pa = '0; cal_pb = '0; cal_m = '0; cal_h = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // all-zero calibration: divisor is zero, humidity collapses to 0
      z = '0;
      z.hv = 1'b1;
      rows.push_back('{24'h000000, 24'h000000, 16'h0000, 1'b1, z});
      rows.push_back('{24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b0, z});
      z.hv = 1'b0;
      rows.push_back('{24'h800000, 24'h800000, 16'h8000, 1'b1, z});
      foreach (rows[i]) send_set(rows[i].t, rows[i].p, rows[i].h, rows[i].known, rows[i].res);
      drain(90);

      load_random_cal(0);
      rows.delete();
      rows.push_back('{24'h800000, 24'h800000, 16'h8000, 1'b1, '0});
      rows.push_back('{24'h800000, 24'h65A000, 16'h6E00, 1'b0, '0});
      rows.push_back('{24'h7E1000, 24'h800000, 16'h6E00, 1'b0, '0});
      rows.push_back('{24'h7E1000, 24'h65A000, 16'h8000, 1'b0, '0});
      rows.push_back('{24'h7E1000, 24'h65A000, 16'h6E00, 1'b0, '0});
      rows.push_back('{24'h000000, 24'h000000, 16'h0000, 1'b0, '0});
      rows.push_back('{24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b0, '0});
      rows.push_back('{24'h7FFFFF, 24'h800001, 16'h7FFF, 1'b0, '0});
      rows.push_back('{24'h800001, 24'h7FFFFF, 16'h8001, 1'b0, '0});
      foreach (rows[i]) send_set(rows[i].t, rows[i].p, rows[i].h, rows[i].known, rows[i].res);
      drain(90);

      // extreme calibrations
      write_cal(CSR_TEMP, 64'h0000_FFFF_FFFF_FFFF);
      write_cal(CSR_PRESS_A, 64'h7FFF_7FFF_7FFF_FFFF);
      write_cal(CSR_PRESS_B, 64'h8000_8000_8000_8000);
      write_cal(CSR_MIXED, 64'hFFFF_8000_FFFF_8000);
      write_cal(CSR_HUM, 64'h0000_0000_7F7F_F800);
      send_set(24'h000000, 24'hFFFFFF, 16'h0000, 1'b0, '0);
      send_set(24'hFFFFFF, 24'h000000, 16'hFFFF, 1'b0, '0);
      send_set(24'h800000, 24'h000010, 16'h1234, 1'b0, '0);
      drain(90);
      write_cal(CSR_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
      write_cal(CSR_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
      write_cal(CSR_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
      write_cal(CSR_MIXED, 64'hFFFF_FFFF_FFFF_FFFF);
      write_cal(CSR_HUM, 64'hFFFF_FFFF_FFFF_FFFF);
      send_set(24'h000000, 24'h000000, 16'h0000, 1'b0, '0);
      send_set(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b0, '0);
      drain(90);

      for (int ph = 0; ph < 6; ph++) begin
         load_random_cal(ph == 0 ? 0 : (ph % 3 == 2 ? 2 : 1));
         idle_en = (ph != 3);
         for (k = 0; k < 155; k++) begin
            t = 24'($urandom);
            p = 24'($urandom);
            h = 16'($urandom);
            case ($urandom_range(9))
               0: t = TEMP_OFF;
               1: p = PRESS_OFF;
               2: h = HUM_OFF;
               3, 4, 5: begin
                  t = 24'h600000 + 24'($urandom_range(24'h300000));
                  p = 24'h400000 + 24'($urandom_range(24'h300000));
                  h = 16'h4000 + 16'($urandom_range(16'h5000));
               end
               default: ;
            endcase
            send_set(t, p, h, 1'b0, '0);
            if (k == 80) drain(0);
         end
         drain(90);
      end

      $display("Sent %0d sample sets over 10 calibration loads, %0d results checked.",
               sets_sent, results_seen);
      if (errors == 0)
         $display("** env_sensor_compensation: PASSED **");
      else
         $display("** env_sensor_compensation: FAILED **");
      $finish;
   end

endmodule

### filelist.f
rtl/esc_pkg.sv
rtl/esc_temp.sv
rtl/esc_div.sv
rtl/esc_press.sv
rtl/esc_hum.sv
rtl/env_sensor_compensation.sv
verif/tb_env_sensor_compensation.sv
